[hw/rtl/spmam_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spmam_pkg: shared definitions of the sparse polynomial merge adder
// Actions, configuration register indexes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package spmam_pkg;

  localparam int unsigned TERMS_DEFAULT = 32;
  localparam int unsigned WORD_W = 64;

  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_START       = 2'd2;

  localparam logic REG_MODULUS      = 1'b0;
  localparam logic REG_COMPARE_MASK = 1'b1;

  localparam logic [WORD_W-1:0] MODULUS_RESET      = 64'd2;
  localparam logic [WORD_W-1:0] COMPARE_MASK_RESET = 64'd0;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SUM    = 6'b001000,
    S_RED    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/spmam_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spmam_in_if / spmam_out_if: stream channels of the merge adder
// Valid/ready channels for input items and for result terms.
// ----------------------------------------------------------------------------
interface spmam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] exponent;
  logic [63:0] coefficient;

  modport source (output valid, action, exponent, coefficient, input ready);
  modport sink   (input valid, action, exponent, coefficient, output ready);
endinterface

interface spmam_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_exponent;
  logic [63:0] result_coefficient;
  logic        last;
  logic        empty_res;
  logic        overflow;

  modport source (output valid, result_exponent, result_coefficient, last, empty_res,
                  overflow, input ready);
  modport sink   (input valid, result_exponent, result_coefficient, last, empty_res,
                  overflow, output ready);
endinterface
`default_nettype wire

[hw/rtl/sparse_poly_merge_add_mod.sv]
// A start item walks both lists: each emitted term passes the fetch and decide
// states (read, compare), and a pair of equal exponents passes fetch, decide, sum
// and reduce; a closing state ends the run. One term is held back to mark the last.
// One item at a time, taken only in idle; compare, add and reduce share a 65-bit adder.
// Reset: counts, overflow flag and output clear; modulus resets to 2 and mask to 0.
// The term memories are not cleared; only loaded entries are read.
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_poly_merge_add_mod: modular sparse polynomial adder
// Loads two sorted term lists and merges them into their sum on a start.
// ----------------------------------------------------------------------------
module sparse_poly_merge_add_mod #(
  parameter int unsigned TERMS = spmam_pkg::TERMS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  spmam_in_if.sink          in_ch,
  spmam_out_if.source       out_ch,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [63:0]  cfg_wdata
);

  localparam int unsigned AW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int unsigned CW = $clog2(TERMS + 1);

  spmam_pkg::state_t state_r, state_nxt;

  logic [127:0] first_mem [TERMS];
  logic [127:0] second_mem [TERMS];
  logic [127:0] rd1_r, rd2_r;

  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic          drop_r, drop_nxt;
  logic [63:0]   mod_r, mod_nxt, mask_r, mask_nxt;
  logic [64:0]   sum_r, sum_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [63:0]   hold_e_r, hold_e_nxt, hold_c_r, hold_c_nxt;
  logic          out_v_r, out_v_nxt;
  logic [63:0]   out_e_r, out_e_nxt, out_c_r, out_c_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic        in_fire, full1, full2, rem1, rem2, out_free, can_push;
  logic        push_req, eq, gt;
  logic [63:0] push_e, push_c, e1, c1, e2, c2, red;
  logic [63:0] alu_a, alu_b;
  logic        alu_ci;
  logic [64:0] alu_s;

  assign e1 = rd1_r[127:64];
  assign c1 = rd1_r[63:0];
  assign e2 = rd2_r[127:64];
  assign c2 = rd2_r[63:0];

  assign in_ch.ready = (state_r == spmam_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full1       = (cnt1_r >= CW'(TERMS));
  assign full2       = (cnt2_r >= CW'(TERMS));
  assign rem1        = (i_r < cnt1_r);
  assign rem2        = (j_r < cnt2_r);
  assign out_free    = !out_v_r || out_ch.ready;
  assign can_push    = !hold_v_r || out_free;

  // One shared adder serves the exponent compare, the coefficient sum and the reduction.
  always_comb begin
    alu_a  = e1 ^ mask_r;
    alu_b  = ~(e2 ^ mask_r);
    alu_ci = 1'b1;
    unique case (state_r)
      spmam_pkg::S_SUM: begin
        alu_a  = c1;
        alu_b  = c2;
        alu_ci = 1'b0;
      end
      spmam_pkg::S_RED: begin
        alu_a  = sum_r[63:0];
        alu_b  = ~mod_r;
        alu_ci = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign alu_s = {1'b0, alu_a} + {1'b0, alu_b} + {64'd0, alu_ci};
  assign eq    = (e1 == e2);
  assign gt    = alu_s[64] && !eq;

  always_comb begin
    if (mod_r == 64'd0) begin
      red = sum_r[63:0];
    end else if (sum_r[64] || alu_s[64]) begin
      red = alu_s[63:0];
    end else begin
      red = sum_r[63:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    drop_nxt      = drop_r;
    mod_nxt       = mod_r;
    mask_nxt      = mask_r;
    sum_nxt       = sum_r;
    hold_v_nxt    = hold_v_r;
    hold_e_nxt    = hold_e_r;
    hold_c_nxt    = hold_c_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_e_nxt     = out_e_r;
    out_c_nxt     = out_c_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    push_req      = 1'b0;
    push_e        = e1;
    push_c        = c1;

    if (cfg_we) begin
      unique case (cfg_index)
        spmam_pkg::REG_MODULUS:      mod_nxt  = cfg_wdata;
        spmam_pkg::REG_COMPARE_MASK: mask_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      spmam_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.action)
            spmam_pkg::ACT_LOAD_FIRST: begin
              if (full1) drop_nxt = 1'b1;
              else cnt1_nxt = cnt1_r + CW'(1);
            end
            spmam_pkg::ACT_LOAD_SECOND: begin
              if (full2) drop_nxt = 1'b1;
              else cnt2_nxt = cnt2_r + CW'(1);
            end
            spmam_pkg::ACT_START: begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = spmam_pkg::S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      spmam_pkg::S_FETCH: begin
        state_nxt = spmam_pkg::S_DECIDE;
      end
      spmam_pkg::S_DECIDE: begin
        priority if (rem1 && rem2 && eq) begin
          state_nxt = spmam_pkg::S_SUM;
        end else if (rem1 && (gt || !rem2)) begin
          push_req = 1'b1;
          if (can_push) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = spmam_pkg::S_FETCH;
          end
        end else if (rem2) begin
          push_req = 1'b1;
          push_e   = e2;
          push_c   = c2;
          if (can_push) begin
            j_nxt     = j_r + CW'(1);
            state_nxt = spmam_pkg::S_FETCH;
          end
        end else begin
          state_nxt = spmam_pkg::S_FIN;
        end
      end
      spmam_pkg::S_SUM: begin
        sum_nxt   = alu_s;
        state_nxt = spmam_pkg::S_RED;
      end
      spmam_pkg::S_RED: begin
        push_c = red;
        if (red == 64'd0 || can_push) begin
          push_req  = (red != 64'd0);
          i_nxt     = i_r + CW'(1);
          j_nxt     = j_r + CW'(1);
          state_nxt = spmam_pkg::S_FETCH;
        end
      end
      spmam_pkg::S_FIN: begin
        if (out_free) begin
          out_v_nxt     = 1'b1;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = drop_r;
          out_empty_nxt = !hold_v_r;
          out_e_nxt     = hold_v_r ? hold_e_r : 64'd0;
          out_c_nxt     = hold_v_r ? hold_c_r : 64'd0;
          hold_v_nxt    = 1'b0;
          cnt1_nxt      = '0;
          cnt2_nxt      = '0;
          drop_nxt      = 1'b0;
          state_nxt     = spmam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spmam_pkg::S_IDLE;
      end
    endcase

    // A new term replaces the held one, which moves to the output register.
    if (push_req && can_push) begin
      if (hold_v_r) begin
        out_v_nxt     = 1'b1;
        out_e_nxt     = hold_e_r;
        out_c_nxt     = hold_c_r;
        out_last_nxt  = 1'b0;
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = drop_r;
      end
      hold_v_nxt = 1'b1;
      hold_e_nxt = push_e;
      hold_c_nxt = push_c;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.action == spmam_pkg::ACT_LOAD_FIRST && !full1) begin
      first_mem[cnt1_r[AW-1:0]] <= {in_ch.exponent, in_ch.coefficient};
    end
    if (in_fire && in_ch.action == spmam_pkg::ACT_LOAD_SECOND && !full2) begin
      second_mem[cnt2_r[AW-1:0]] <= {in_ch.exponent, in_ch.coefficient};
    end
    rd1_r <= first_mem[i_r[AW-1:0]];
    rd2_r <= second_mem[j_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= spmam_pkg::S_IDLE;
      cnt1_r   <= '0;
      cnt2_r   <= '0;
      drop_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      mod_r    <= spmam_pkg::MODULUS_RESET;
      mask_r   <= spmam_pkg::COMPARE_MASK_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt1_r   <= cnt1_nxt;
      cnt2_r   <= cnt2_nxt;
      drop_r   <= drop_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      mod_r    <= mod_nxt;
      mask_r   <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    sum_r       <= sum_nxt;
    hold_e_r    <= hold_e_nxt;
    hold_c_r    <= hold_c_nxt;
    out_e_r     <= out_e_nxt;
    out_c_r     <= out_c_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.result_exponent    = out_e_r;
  assign out_ch.result_coefficient = out_c_r;
  assign out_ch.last               = out_last_r;
  assign out_ch.empty_res          = out_empty_r;
  assign out_ch.overflow           = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt1_r <= CW'(TERMS) && cnt2_r <= CW'(TERMS))
    else $error("term count exceeds capacity");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_empty_r |-> out_last_r && out_e_r == 64'd0 && out_c_r == 64'd0)
    else $error("empty result is not a zero last transfer");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spmam_pkg::S_IDLE |-> !hold_v_r)
    else $error("held term left over after a merge run");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != spmam_pkg::S_IDLE |-> i_r <= cnt1_r && j_r <= cnt2_r)
    else $error("list walk beyond loaded terms");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spmam_pkg::S_FIN && out_free |=> cnt1_r == '0 && cnt2_r == '0 && !drop_r)
    else $error("lists not cleared after merge run");

endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sparse polynomial merge adder
// A short table of directed items is followed by random, mostly well-formed term
// lists under several modulus and mask settings. Result terms are checked in order
// against the table's term where a step gives one, else a behavioral merge of the lists.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH = spmam_pkg::TERMS_DEFAULT;
  localparam int SETTLE_CYCLES = 20;
  localparam int DIRECTED_LEN = 31;
  localparam int PHASE_ITEMS = 40;
  localparam int PHASES = 6;
  localparam logic [1:0] ACT_LOAD_FIRST = spmam_pkg::ACT_LOAD_FIRST;
  localparam logic [1:0] ACT_LOAD_SECOND = spmam_pkg::ACT_LOAD_SECOND;
  localparam logic [1:0] ACT_START = spmam_pkg::ACT_START;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic REG_MODULUS = spmam_pkg::REG_MODULUS;
  localparam logic REG_COMPARE_MASK = spmam_pkg::REG_COMPARE_MASK;
  localparam logic [63:0] ONES = '1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] exponent;
    logic [63:0] coefficient;
  } item_t;

  typedef struct packed {
    logic [63:0] exponent;
    logic [63:0] coefficient;
    logic        last;
    logic        empty_res;
    logic        overflow;
  } term_t;

  typedef struct packed {
    logic        is_cfg;
    logic        reg_idx;
    logic [63:0] cfg_value;
    item_t       item;
    logic        typed;
    term_t       want;
  } step_t;

  localparam term_t NO_TERM = '0;
  localparam item_t NO_ITEM = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;

  spmam_in_if  in_ch ();
  spmam_out_if out_ch ();

  sparse_poly_merge_add_mod u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  logic [63:0] held_exp [2][LIST_DEPTH];
  logic [63:0] held_coef [2][LIST_DEPTH];
  int          held_count [2];
  logic        drop_seen;
  logic [63:0] modulus_reg;
  logic [63:0] mask_reg;

  term_t       expected_terms [$];
  term_t       head_term;
  int          mismatches = 0;
  logic        idle_on = 1'b1;
  int          stall_left = 0;
  logic [63:0] draw_keys [2][40];
  logic [63:0] draw_coefs [2][40];

  step_t directed_steps [DIRECTED_LEN] = '{
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd0, 64'd0, 1'b1, 1'b1, 1'b0}},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_UNUSED, ONES, ONES}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd5, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd5, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd0, 64'd0, 1'b1, 1'b1, 1'b0}},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, ONES, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{ONES, 64'd1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd0, ONES}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd0, ONES, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd7, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd5, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd3, 64'd1}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd3, 64'd0}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b0, NO_TERM},
    '{1'b1, REG_MODULUS, 64'd0, NO_ITEM, 1'b0, NO_TERM},
    '{1'b1, REG_COMPARE_MASK, ONES, NO_ITEM, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd1, ONES}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd1, 64'd2}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd1, 64'd1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd0, 64'd3}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, ONES, 64'd4}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd8, 64'd5}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b0, NO_TERM},
    '{1'b1, REG_MODULUS, ONES, NO_ITEM, 1'b0, NO_TERM},
    '{1'b1, REG_COMPARE_MASK, 64'd0, NO_ITEM, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b0,
      NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_SECOND, 64'd2, 64'hFFFF_FFFF_FFFF_FFFE}, 1'b0,
      NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd2, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1, 1'b0, 1'b0}},
    '{1'b1, REG_MODULUS, 64'd1, NO_ITEM, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_LOAD_FIRST, 64'd4, 64'd0}, 1'b0, NO_TERM},
    '{1'b0, REG_MODULUS, 64'd0, '{ACT_START, 64'd0, 64'd0}, 1'b1,
      '{64'd4, 64'd0, 1'b1, 1'b0, 1'b0}}
  };

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      2, 3: return 64'($urandom_range(0, 15));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] rand_coef();
    if ($urandom_range(0, 15) == 0 || modulus_reg == '0) begin
      return rand64();
    end
    return rand64() % modulus_reg;
  endfunction

  // The sum is formed in 65 bits so the carry out of the word is kept.
  task automatic merge_predict(input item_t it, input logic typed, input term_t want);
    int          i;
    int          j;
    int          side;
    logic [64:0] total;
    term_t       run [$];
    i = 0;
    j = 0;
    if (it.action == ACT_LOAD_FIRST || it.action == ACT_LOAD_SECOND) begin
      side = (it.action == ACT_LOAD_SECOND) ? 1 : 0;
      if (held_count[side] < LIST_DEPTH) begin
        held_exp[side][held_count[side]] = it.exponent;
        held_coef[side][held_count[side]] = it.coefficient;
        held_count[side]++;
      end else begin
        drop_seen = 1'b1;
      end
    end else if (it.action == ACT_START) begin
      while (i < held_count[0] || j < held_count[1]) begin
        if (i < held_count[0] && j < held_count[1] &&
            (held_exp[0][i] ^ mask_reg) == (held_exp[1][j] ^ mask_reg)) begin
          total = {1'b0, held_coef[0][i]} + {1'b0, held_coef[1][j]};
          if (modulus_reg != '0 && total >= {1'b0, modulus_reg}) begin
            total = total - {1'b0, modulus_reg};
          end
          if (total[63:0] != '0) begin
            run.push_back('{held_exp[0][i], total[63:0], 1'b0, 1'b0, drop_seen});
          end
          i++;
          j++;
        end else if (j >= held_count[1] || (i < held_count[0] &&
                     (held_exp[0][i] ^ mask_reg) > (held_exp[1][j] ^ mask_reg))) begin
          run.push_back('{held_exp[0][i], held_coef[0][i], 1'b0, 1'b0, drop_seen});
          i++;
        end else begin
          run.push_back('{held_exp[1][j], held_coef[1][j], 1'b0, 1'b0, drop_seen});
          j++;
        end
      end
      if (run.size() == 0) begin
        run.push_back('{64'd0, 64'd0, 1'b0, 1'b1, drop_seen});
      end
      run[run.size() - 1].last = 1'b1;
      if (!typed) begin
        foreach (run[n]) expected_terms.push_back(run[n]);
      end
      held_count[0] = 0;
      held_count[1] = 0;
      drop_seen = 1'b0;
    end
    if (typed) begin
      expected_terms.push_back(want);
    end
  endtask

  task automatic send_item(input item_t it, input logic typed, input term_t want);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = it.action;
    in_ch.exponent = it.exponent;
    in_ch.coefficient = it.coefficient;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    merge_predict(it, typed, want);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MODULUS) begin
      modulus_reg = value;
    end else begin
      mask_reg = value;
    end
  endtask

  task automatic sort_draw(input int l, input int n);
    int          a;
    int          b;
    logic [63:0] k;
    logic [63:0] c;
    for (a = 1; a < n; a++) begin
      k = draw_keys[l][a];
      c = draw_coefs[l][a];
      b = a - 1;
      while (b >= 0 && draw_keys[l][b] < k) begin
        draw_keys[l][b + 1] = draw_keys[l][b];
        draw_coefs[l][b + 1] = draw_coefs[l][b];
        b--;
      end
      draw_keys[l][b + 1] = k;
      draw_coefs[l][b + 1] = c;
    end
  endtask

  // Lists are drawn as keys, mostly sorted in descending order, and sent as key XOR mask,
  // with part of the second list sharing keys of the first so that terms meet.
  task automatic play_sequence(input logic go_long, output int sent, output logic started);
    int    len [2];
    int    i;
    int    j;
    int    pick;
    item_t it;
    sent = 0;
    for (i = 0; i < 2; i++) begin
      len[i] = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    end
    if (go_long) begin
      len[0] = 34;
      len[1] = 33;
    end
    for (i = 0; i < len[0]; i++) begin
      draw_keys[0][i] = rand_key();
      draw_coefs[0][i] = rand_coef();
    end
    for (j = 0; j < len[1]; j++) begin
      if (len[0] != 0 && $urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, len[0] - 1);
        draw_keys[1][j] = draw_keys[0][pick];
        draw_coefs[1][j] = ($urandom_range(0, 2) == 0) ?
                           modulus_reg - draw_coefs[0][pick] : rand_coef();
      end else begin
        draw_keys[1][j] = rand_key();
        draw_coefs[1][j] = rand_coef();
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      sort_draw(0, len[0]);
      sort_draw(1, len[1]);
    end
    i = 0;
    j = 0;
    while (i < len[0] || j < len[1]) begin
      if ($urandom_range(0, 19) == 0) begin
        it = '{ACT_UNUSED, rand64(), rand64()};
        send_item(it, 1'b0, NO_TERM);
      end
      if (j >= len[1] || (i < len[0] && $urandom_range(0, 1) == 0)) begin
        it = '{ACT_LOAD_FIRST, draw_keys[0][i] ^ mask_reg, draw_coefs[0][i]};
        i++;
      end else begin
        it = '{ACT_LOAD_SECOND, draw_keys[1][j] ^ mask_reg, draw_coefs[1][j]};
        j++;
      end
      send_item(it, 1'b0, NO_TERM);
      sent++;
    end
    started = ($urandom_range(0, 9) != 0);
    if (started) begin
      it = '{ACT_START, rand64(), rand64()};
      send_item(it, 1'b0, NO_TERM);
      sent++;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_terms.size() == 0) begin
        $error("result transfer with no term expected");
        mismatches++;
      end else begin
        head_term = expected_terms.pop_front();
        check_field("result_exponent", head_term.exponent, out_ch.result_exponent);
        check_field("result_coefficient", head_term.coefficient, out_ch.result_coefficient);
        check_field("last", 64'(head_term.last), 64'(out_ch.last));
        check_field("empty_res", 64'(head_term.empty_res), 64'(out_ch.empty_res));
        check_field("overflow", 64'(head_term.overflow), 64'(out_ch.overflow));
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          phase;
    int          phase_items;
    int          sent;
    logic        started;
    logic [63:0] new_modulus;
    logic [63:0] new_mask;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOAD_FIRST;
    in_ch.exponent = '0;
    in_ch.coefficient = '0;
    held_count[0] = 0;
    held_count[1] = 0;
    drop_seen = 1'b0;
    modulus_reg = spmam_pkg::MODULUS_RESET;
    mask_reg = spmam_pkg::COMPARE_MASK_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[s]) begin
      if (directed_steps[s].is_cfg) begin
        write_reg(directed_steps[s].reg_idx, directed_steps[s].cfg_value);
      end else begin
        send_item(directed_steps[s].item, directed_steps[s].typed, directed_steps[s].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          new_modulus = rand64();
          new_mask = '0;
        end
        1: begin
          new_modulus = ONES;
          new_mask = ONES;
        end
        2: begin
          new_modulus = '0;
          new_mask = rand64();
        end
        3: begin
          new_modulus = 64'($urandom_range(1, 16));
          new_mask = rand64();
        end
        4: begin
          new_modulus = 64'd1;
          new_mask = rand64();
        end
        default: begin
          new_modulus = rand64();
          new_mask = rand64();
        end
      endcase
      write_reg(REG_MODULUS, new_modulus);
      write_reg(REG_COMPARE_MASK, new_mask);
      idle_on = (phase != PHASES - 1);
      phase_items = 0;
      do begin
        play_sequence(phase == 0 && phase_items == 0, sent, started);
        phase_items += sent;
      end while (phase_items < PHASE_ITEMS || !started);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/spmam_pkg.sv
hw/rtl/spmam_if.sv
hw/rtl/sparse_poly_merge_add_mod.sv
tb/testbench.sv
